### sv/btlv_pkg.sv
`timescale 1ns / 1ps

package btlv_pkg;

    // Accumulator widths; the result ports carry the low 32 bits.
    localparam int TAG_BITS    = 32;
    localparam int LENGTH_BITS = 32;
    localparam int OUT_BITS    = 32;

    localparam logic [1:0] KIND_TAG    = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;
    localparam logic [1:0] KIND_REST   = 2'd3;

    localparam logic [2:0] PH_TAG_FIRST = 3'd0;
    localparam logic [2:0] PH_TAG_MORE  = 3'd1;
    localparam logic [2:0] PH_LEN_FIRST = 3'd2;
    localparam logic [2:0] PH_LEN_MORE  = 3'd3;
    localparam logic [2:0] PH_VALUE     = 3'd4;
    localparam logic [2:0] PH_REST      = 3'd5;

    typedef struct packed {
        logic [7:0]          byte_out;
        logic [1:0]          kind;
        logic [OUT_BITS-1:0] tag_value;
        logic [OUT_BITS-1:0] value_length;
        logic                header_done;
        logic                error;
        logic                last_out;
    } t_result;

endpackage

### sv/ber_tlv_decoder_core.sv
`timescale 1ns / 1ps

// BER-TLV header decoder. Feed the encoded buffer one byte per beat, with
// i_last high on its final byte; every input beat yields exactly one result
// beat that labels the byte as tag, length, value or rest and carries the tag
// and length decoded so far. The block takes one byte per clock while
// o_in_stall is low: the state update is a single step of logic from the
// parser registers, and each result is registered. A two-entry output (result
// register plus skid register) keeps accepting while a result waits, so
// o_in_stall rises only once both entries are full. o_error is meaningful on
// the last byte only: it flags a truncated header or value bytes still owed.
// After the last byte the parser returns to its reset state for a new buffer.
module ber_tlv_decoder_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_byte_out,
    output logic [1:0]                o_kind,
    output logic [btlv_pkg::OUT_BITS-1:0] o_tag_value,
    output logic [btlv_pkg::OUT_BITS-1:0] o_value_length,
    output logic                      o_header_done,
    output logic                      o_error,
    output logic                      o_last_out
);
    import btlv_pkg::*;

    logic [2:0]             r_phase,      n_phase;
    logic [TAG_BITS-1:0]    r_tag,        n_tag;
    logic [LENGTH_BITS-1:0] r_length,     n_length;
    logic [6:0]             r_len_left,   n_len_left;
    logic [LENGTH_BITS-1:0] r_value_left, n_value_left;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic                   in_accept;
    logic                   out_take;
    logic [1:0]             kind;
    logic                   done;
    logic                   err;
    logic [6:0]             len_left_dec;
    logic [LENGTH_BITS-1:0] len_shifted;
    logic [63:0]            tag_wide;
    logic [63:0]            length_wide;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    assign len_left_dec = r_len_left - 7'd1;
    assign len_shifted  = (r_length << 8) | LENGTH_BITS'(i_data_byte);

    always_comb begin
        n_phase      = r_phase;
        n_tag        = r_tag;
        n_length     = r_length;
        n_len_left   = r_len_left;
        n_value_left = r_value_left;
        kind         = KIND_REST;
        unique case (r_phase)
            PH_TAG_FIRST: begin
                kind     = KIND_TAG;
                n_tag    = TAG_BITS'(i_data_byte);
                n_length = '0;
                n_phase  = (i_data_byte[4:0] == 5'h1F) ? PH_TAG_MORE : PH_LEN_FIRST;
            end
            PH_TAG_MORE: begin
                kind  = KIND_TAG;
                n_tag = (r_tag << 8) | TAG_BITS'(i_data_byte);
                if (!i_data_byte[7]) begin
                    n_phase = PH_LEN_FIRST;
                end
            end
            PH_LEN_FIRST: begin
                kind = KIND_LENGTH;
                if (!i_data_byte[7]) begin
                    n_length     = LENGTH_BITS'(i_data_byte);
                    n_value_left = LENGTH_BITS'(i_data_byte);
                    n_phase      = (i_data_byte != 8'd0) ? PH_VALUE : PH_REST;
                end else begin
                    n_length   = '0;
                    n_len_left = i_data_byte[6:0];
                    if (i_data_byte[6:0] == 7'd0) begin
                        // Indefinite form: no length bytes, length zero.
                        n_value_left = '0;
                        n_phase      = PH_REST;
                    end else begin
                        n_phase = PH_LEN_MORE;
                    end
                end
            end
            PH_LEN_MORE: begin
                kind       = KIND_LENGTH;
                n_length   = len_shifted;
                n_len_left = len_left_dec;
                if (len_left_dec == 7'd0) begin
                    n_value_left = len_shifted;
                    n_phase      = (len_shifted != '0) ? PH_VALUE : PH_REST;
                end
            end
            PH_VALUE: begin
                kind = KIND_VALUE;
                if (r_value_left != '0) begin
                    n_value_left = r_value_left - LENGTH_BITS'(1);
                end
                if (n_value_left == '0) begin
                    n_phase = PH_REST;
                end
            end
            default: begin
                kind    = KIND_REST;
                n_phase = PH_REST;
            end
        endcase

        done = (n_phase == PH_VALUE) || (n_phase == PH_REST);
        err  = i_last && (!done || ((n_phase == PH_VALUE) && (n_value_left != '0)));

        tag_wide    = 64'(n_tag);
        length_wide = 64'(n_length);

        n_result.byte_out     = i_data_byte;
        n_result.kind         = kind;
        n_result.tag_value    = tag_wide[OUT_BITS-1:0];
        n_result.value_length = length_wide[OUT_BITS-1:0];
        n_result.header_done  = done;
        n_result.error        = err;
        n_result.last_out     = i_last;
    end

    // Parser state; the end of a buffer returns it to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_accept && i_last)) begin
            r_phase      <= PH_TAG_FIRST;
            r_tag        <= '0;
            r_length     <= '0;
            r_len_left   <= '0;
            r_value_left <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_tag        <= n_tag;
            r_length     <= n_length;
            r_len_left   <= n_len_left;
            r_value_left <= n_value_left;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_out.byte_out;
    assign o_kind         = r_out.kind;
    assign o_tag_value    = r_out.tag_value;
    assign o_value_length = r_out.value_length;
    assign o_header_done  = r_out.header_done;
    assign o_error        = r_out.error;
    assign o_last_out     = r_out.last_out;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a beat while the output register is empty");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last) |=> (r_phase == PH_TAG_FIRST))
        else $error("parser did not restart after the last byte");

    a_value_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_value_left != '0))
        else $error("value phase with no value bytes owed");

    a_error_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> o_last_out)
        else $error("error flagged on a byte that is not the last");
`endif

endmodule

### tb/tb_ber_tlv_decoder_core.sv
`timescale 1ns / 1ps

module tb_ber_tlv_decoder_core;
    import btlv_pkg::*;

    // Labels each accepted byte the way the decoder should and keeps the
    // expected result beats in arrival order.
    class tlv_label_board;
        t_result expected_labels[$];
        int mismatches = 0;

        logic [2:0]             phase = PH_TAG_FIRST;
        logic [TAG_BITS-1:0]    tag_acc = '0;
        logic [LENGTH_BITS-1:0] len_acc = '0;
        logic [6:0]             len_bytes_left = '0;
        logic [LENGTH_BITS-1:0] value_left = '0;

        function void close_header();
            value_left = len_acc;
            phase = (value_left != 0) ? PH_VALUE : PH_REST;
        endfunction

        function void predict_label(logic [7:0] b, logic is_last);
            t_result r;
            logic [1:0] kind;
            logic done;
            kind = KIND_REST;
            case (phase)
                PH_TAG_FIRST: begin
                    kind = KIND_TAG;
                    tag_acc = TAG_BITS'(b);
                    len_acc = '0;
                    phase = (b[4:0] == 5'h1F) ? PH_TAG_MORE : PH_LEN_FIRST;
                end
                PH_TAG_MORE: begin
                    kind = KIND_TAG;
                    tag_acc = (tag_acc << 8) | TAG_BITS'(b);
                    if (!b[7])
                        phase = PH_LEN_FIRST;
                end
                PH_LEN_FIRST: begin
                    kind = KIND_LENGTH;
                    if (!b[7]) begin
                        len_acc = LENGTH_BITS'(b);
                        close_header();
                    end else begin
                        len_acc = '0;
                        len_bytes_left = b[6:0];
                        if (len_bytes_left == 0)
                            close_header();
                        else
                            phase = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE: begin
                    kind = KIND_LENGTH;
                    len_acc = (len_acc << 8) | LENGTH_BITS'(b);
                    len_bytes_left = len_bytes_left - 7'd1;
                    if (len_bytes_left == 0)
                        close_header();
                end
                PH_VALUE: begin
                    kind = KIND_VALUE;
                    if (value_left != 0)
                        value_left = value_left - 1;
                    if (value_left == 0)
                        phase = PH_REST;
                end
                default: begin
                    kind = KIND_REST;
                    phase = PH_REST;
                end
            endcase

            done = (phase == PH_VALUE) || (phase == PH_REST);
            r.byte_out     = b;
            r.kind         = kind;
            r.tag_value    = tag_acc[OUT_BITS-1:0];
            r.value_length = len_acc[OUT_BITS-1:0];
            r.header_done  = done;
            r.error        = is_last && (!done || (phase == PH_VALUE && value_left != 0));
            r.last_out     = is_last;
            expected_labels.insert(expected_labels.size(), r);

            // The last byte of a buffer sends the parser back to its reset state.
            if (is_last) begin
                phase = PH_TAG_FIRST;
                tag_acc = '0;
                len_acc = '0;
                len_bytes_left = '0;
                value_left = '0;
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            end
        endfunction

        function void check_label(t_result got);
            t_result want;
            if (expected_labels.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, expected none, got 0x%0h",
                         $time, got);
                return;
            end
            want = expected_labels.pop_front();
            report("byte_out", 32'(want.byte_out), 32'(got.byte_out));
            report("kind", 32'(want.kind), 32'(got.kind));
            report("tag_value", 32'(want.tag_value), 32'(got.tag_value));
            report("value_length", 32'(want.value_length), 32'(got.value_length));
            report("header_done", 32'(want.header_done), 32'(got.header_done));
            report("error", 32'(want.error), 32'(got.error));
            report("last_out", 32'(want.last_out), 32'(got.last_out));
        endfunction

        function int pending();
            return expected_labels.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_byte_out;
    logic [1:0]  o_kind;
    logic [OUT_BITS-1:0] o_tag_value;
    logic [OUT_BITS-1:0] o_value_length;
    logic        o_header_done;
    logic        o_error;
    logic        o_last_out;

    t_result     seen_label;
    tlv_label_board board = new();

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int beats_sent = 0;
    logic [7:0] frame_q[$];

    ber_tlv_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_out     (o_byte_out),
        .o_kind         (o_kind),
        .o_tag_value    (o_tag_value),
        .o_value_length (o_value_length),
        .o_header_done  (o_header_done),
        .o_error        (o_error),
        .o_last_out     (o_last_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    assign seen_label = {o_byte_out, o_kind, o_tag_value, o_value_length,
                         o_header_done, o_error, o_last_out};

    // A long hold-off takes precedence over the random stall pattern.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_label(seen_label);
    end

    task automatic send_beat(input logic [7:0] b, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        board.predict_label(b, is_last);
        beats_sent++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endtask

    // One tag, one length and the value, plus up to two trailing bytes.
    task automatic build_tlv();
        logic [7:0] t;
        int vlen;
        int n_len;
        int n_rest;
        t = 8'($urandom);
        if ($urandom_range(1) == 0) begin
            if (t[4:0] == 5'h1F)
                t[0] = 1'b0;
            add_byte(t);
        end else begin
            t[4:0] = 5'h1F;
            add_byte(t);
            repeat ($urandom_range(5)) begin
                t = 8'($urandom);
                t[7] = 1'b1;
                add_byte(t);
            end
            t = 8'($urandom);
            t[7] = 1'b0;
            add_byte(t);
        end

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: vlen = $urandom_range(8);
            6, 7:             vlen = $urandom_range(40, 9);
            8:                vlen = 0;
            default:          vlen = $urandom_range(200, 41);
        endcase

        if (vlen < 128 && $urandom_range(2) != 0) begin
            add_byte(8'(vlen));
        end else if (vlen == 0 && $urandom_range(1) == 0) begin
            add_byte(8'h80);
        end else begin
            // Bytes above the low four shift out of the accumulator.
            n_len = $urandom_range(7, 1);
            add_byte(8'h80 | 8'(n_len));
            for (int i = n_len - 1; i >= 0; i--) begin
                if (i >= 4)
                    add_byte(8'($urandom));
                else if (i == 0)
                    add_byte(8'(vlen));
                else
                    add_byte(8'h00);
            end
        end

        repeat (vlen) add_byte(8'($urandom));
        n_rest = $urandom_range(2);
        repeat (n_rest) add_byte(8'($urandom));
    endtask

    task automatic send_random_buffer();
        int pick;
        int keep;
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick < 85) begin
            build_tlv();
            // Cut short: a truncated header, value or trailing bytes.
            if (pick >= 70 && frame_q.size() > 1) begin
                keep = $urandom_range(frame_q.size() - 1, 1);
                while (frame_q.size() > keep)
                    void'(frame_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
        end
        foreach (frame_q[i])
            send_beat(frame_q[i], i == frame_q.size() - 1);
    endtask

    initial begin
        logic [8:0] warmup_q[$];
        int target;
        warmup_q = '{
            9'h000, 9'h000, 9'h1FF,
            9'h0FF, 9'h0FF, 9'h07F, 9'h180,
            9'h01F, 9'h09F, 9'h081, 9'h080, 9'h001, 9'h082, 9'h000, 9'h002, 9'h0AA,
            9'h155,
            9'h004, 9'h085, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h101,
            9'h13F
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (warmup_q[i])
            send_beat(warmup_q[i][7:0], warmup_q[i][8]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            // Long receiver hold-off while bytes keep coming, so the input stalls.
            if (ph == 2)
                hold_left = 120;
            // The sender waits here until every result has drained.
            if (ph == 3) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end
            target = beats_sent + 425;
            while (beats_sent < target)
                send_random_buffer();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS ber_tlv_decoder_core");
        else
            $display("FAIL ber_tlv_decoder_core");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL ber_tlv_decoder_core");
        $finish;
    end

endmodule
